FILE: rtl/prl_pkg.sv
package prl_pkg;

    localparam int MAX_FRAMES = 512;
    localparam int PAGE_W     = 20;
    localparam int FC_W       = 10;
    localparam int CNT_TOT_W  = 32;

    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FILL_W  = $clog2(MAX_FRAMES + 1);
    localparam int CNT_W   = (FILL_W > FC_W) ? FILL_W : FC_W;

    // match tree: 8-way nodes, one register level per node level
    localparam int LVLS    = (IDX_W + 2) / 3;
    localparam int PAD_W   = 3 * LVLS;
    localparam int PAD     = 1 << PAD_W;
    localparam int NODES   = PAD / 8;
    localparam int LVL_W   = (LVLS > 1) ? $clog2(LVLS) : 1;

    localparam int IN_TDATA_W  = ((PAGE_W + 7) / 8) * 8;
    localparam int RES_W       = 2 + PAGE_W + 2 * CNT_TOT_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    typedef struct packed {
        logic              fill;
        logic              shift;
        logic [IDX_W-1:0]  fill_pos;
        logic [IDX_W-1:0]  start;
        logic [IDX_W-1:0]  last;
        logic [PAGE_W-1:0] page;
    } t_cell_ctl;

endpackage

FILE: rtl/prl_cell.sv
module prl_cell import prl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_pos,
    input  t_cell_ctl         i_ctl,
    input  logic [PAGE_W-1:0] i_next_tag,
    output logic [PAGE_W-1:0] o_tag,
    output logic              o_valid,
    output logic              o_match
);

    logic [PAGE_W-1:0] r_tag;
    logic              r_valid;
    logic              r_match;
    logic              w_fill_here;

    assign w_fill_here = i_ctl.fill && (i_pos == i_ctl.fill_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (w_fill_here) begin
                r_valid <= 1'b1;
            end
            r_match <= r_valid && (r_tag == i_ctl.page);
        end
    end

    // ordered by age: position 0 is the oldest, the newest sits at last
    always_ff @(posedge i_clk) begin
        if (w_fill_here) begin
            r_tag <= i_ctl.page;
        end else if (i_ctl.shift && r_valid) begin
            if (i_pos == i_ctl.last) begin
                r_tag <= i_ctl.page;
            end else if (i_pos >= i_ctl.start && i_pos < i_ctl.last) begin
                r_tag <= i_next_tag;
            end
        end
    end

    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

FILE: rtl/prl_tree.sv
module prl_tree import prl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [MAX_FRAMES-1:0] i_match,
    output logic                  o_hit,
    output logic [IDX_W-1:0]      o_pos
);

    logic [PAD-1:0]   w_leaf;
    logic             r_any [LVLS][NODES];
    logic [PAD_W-1:0] r_idx [LVLS][NODES];
    logic             n_any [LVLS][NODES];
    logic [PAD_W-1:0] n_idx [LVLS][NODES];

    assign w_leaf = PAD'(i_match);

    // at most one leaf is set, so an OR of the indices gives the position
    always_comb begin
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < NODES; j++) begin
                n_any[l][j] = 1'b0;
                n_idx[l][j] = '0;
            end
        end
        for (int j = 0; j < NODES; j++) begin
            for (int c = 0; c < 8; c++) begin
                if (w_leaf[j*8 + c]) begin
                    n_any[0][j] = 1'b1;
                    n_idx[0][j] = n_idx[0][j] | PAD_W'(j*8 + c);
                end
            end
        end
        for (int l = 1; l < LVLS; l++) begin
            for (int j = 0; j < NODES; j++) begin
                for (int c = 0; c < 8; c++) begin
                    if (j*8 + c < NODES) begin
                        n_any[l][j] = n_any[l][j] | r_any[l-1][j*8 + c];
                        n_idx[l][j] = n_idx[l][j] | r_idx[l-1][j*8 + c];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LVLS; l++) begin
                for (int j = 0; j < NODES; j++) begin
                    r_any[l][j] <= 1'b0;
                end
            end
        end else begin
            for (int l = 0; l < LVLS; l++) begin
                for (int j = 0; j < NODES; j++) begin
                    r_any[l][j] <= n_any[l][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < NODES; j++) begin
                r_idx[l][j] <= n_idx[l][j];
            end
        end
    end

    assign o_hit = r_any[LVLS-1][0];
    assign o_pos = r_idx[LVLS-1][0][IDX_W-1:0];

endmodule

FILE: rtl/page_replacement_fifo_lru.sv
// Channel   Direction  Handshake                   Payload
// s_axis    in         i_s_axis_tvalid/o_..tready   tdata[19:0] page_number
// m_axis    out        o_m_axis_tvalid/i_..tready   tdata: hit, evict_valid, evicted_page,
//                                                   total_hits, total_misses
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each page passes the accept state, the compare state, LVLS levels of the registered
// 8-way match tree and the update state, in which the cell row shifts.
// Synchronous active-low reset clears all valid bits, the fill count and the totals.
// The result sits in an output register; a stalled master side holds the update cycle.
// A new page is taken as soon as the update has moved its result to that register.
module page_replacement_fifo_lru import prl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [19:0] page_number
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // hit, evict_valid, evicted_page,
                                                    // total_hits, total_misses
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [FC_W-1:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_TREE = 4'b0100,
        ST_UPD  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [LVL_W-1:0]       r_lvl;
    logic [PAGE_W-1:0]      r_page;
    logic                   r_policy;
    logic [FC_W-1:0]        r_frame_count;
    logic [FILL_W-1:0]      r_filled;
    logic [CNT_TOT_W-1:0]   r_hits;
    logic [CNT_TOT_W-1:0]   r_misses;

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic                   r_out_ev;
    logic [PAGE_W-1:0]      r_out_evpage;
    logic [CNT_TOT_W-1:0]   r_out_hits;
    logic [CNT_TOT_W-1:0]   r_out_misses;

    logic [PAGE_W-1:0]      w_tag [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  w_valid;
    logic [MAX_FRAMES-1:0]  w_match;
    logic                   w_hit;
    logic [IDX_W-1:0]       w_pos;
    logic [CNT_W-1:0]       w_eff;
    logic                   w_go;
    logic                   w_fill;
    logic                   w_evict;
    t_cell_ctl              w_ctl;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_go = (r_state == ST_UPD) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= POL_FIFO;
            r_frame_count <= FC_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLICY: r_policy      <= i_cfg_data[0];
                CFG_FRAMES: r_frame_count <= i_cfg_data;
                default:    r_policy      <= r_policy;
            endcase
        end
    end

    always_comb begin
        if (r_frame_count == '0) begin
            w_eff = CNT_W'(1);
        end else if (CNT_W'(r_frame_count) > CNT_W'(MAX_FRAMES)) begin
            w_eff = CNT_W'(MAX_FRAMES);
        end else begin
            w_eff = CNT_W'(r_frame_count);
        end
    end

    assign w_fill  = !w_hit && (CNT_W'(r_filled) < w_eff);
    assign w_evict = !w_hit && !w_fill;

    always_comb begin
        w_ctl          = '0;
        w_ctl.page     = r_page;
        w_ctl.fill_pos = r_filled[IDX_W-1:0];
        w_ctl.last     = IDX_W'(r_filled - FILL_W'(1));
        w_ctl.start    = w_hit ? w_pos : '0;
        w_ctl.fill     = w_go && w_fill;
        w_ctl.shift    = w_go && ((w_hit && r_policy == POL_LRU) || w_evict);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_s_axis_tvalid) n_state = ST_CMP;
            ST_CMP:  n_state = ST_TREE;
            ST_TREE: if (r_lvl == LVL_W'(LVLS - 1)) n_state = ST_UPD;
            ST_UPD:  if (w_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_TREE) begin
                r_lvl <= r_lvl + LVL_W'(1);
            end else begin
                r_lvl <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_page <= i_s_axis_tdata[PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (w_go) begin
            if (w_fill) begin
                r_filled <= r_filled + FILL_W'(1);
            end
            if (w_hit && r_hits != '1) begin
                r_hits <= r_hits + CNT_TOT_W'(1);
            end
            if (!w_hit && r_misses != '1) begin
                r_misses <= r_misses + CNT_TOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_hit    <= w_hit;
            r_out_ev     <= w_evict;
            r_out_evpage <= w_evict ? w_tag[0] : '0;
            r_out_hits   <= (w_hit && r_hits != '1) ? r_hits + CNT_TOT_W'(1) : r_hits;
            r_out_misses <= (!w_hit && r_misses != '1) ? r_misses + CNT_TOT_W'(1)
                                                       : r_misses;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_misses, r_out_hits, r_out_evpage,
                                           r_out_ev, r_out_hit});

    for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
        logic [PAGE_W-1:0] w_next;
        if (k + 1 < MAX_FRAMES) begin : g_mid
            assign w_next = w_tag[k+1];
        end else begin : g_end
            assign w_next = '0;
        end
        prl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pos      (IDX_W'(k)),
            .i_ctl      (w_ctl),
            .i_next_tag (w_next),
            .o_tag      (w_tag[k]),
            .o_valid    (w_valid[k]),
            .o_match    (w_match[k])
        );
    end

    prl_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_pos   (w_pos)
    );

    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one frame matches the page");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_filled))
        else $error("valid frames disagree with fill count");

    a_fill_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_filled) <= MAX_FRAMES)
        else $error("fill count beyond table depth");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_out_hit && r_out_ev))
        else $error("hit reported together with an eviction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (o_m_axis_tvalid && r_state == ST_IDLE))
        else $error("update without a result transfer pending");

endmodule

FILE: bench/page_replacement_fifo_lru_tb.sv
module page_replacement_fifo_lru_tb;
    import prl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int AWAIT_DEPTH    = 16;
    localparam int POOL_DEPTH     = 256;

    // result fields, hit in the lowest bit
    typedef struct packed {
        logic [CNT_TOT_W-1:0] misses;
        logic [CNT_TOT_W-1:0] hits;
        logic [PAGE_W-1:0]    victim;
        logic                 victim_vld;
        logic                 hit;
    } access_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = CFG_POLICY;
    logic [FC_W-1:0]        i_cfg_data = '0;

    page_replacement_fifo_lru dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // frame table model
    logic [PAGE_W-1:0]    tag_mem   [MAX_FRAMES];
    bit                   valid_mem [MAX_FRAMES];
    int                   rank_mem  [MAX_FRAMES];
    int                   n_filled = 0;
    logic [CNT_TOT_W-1:0] hit_total_q = '0;
    logic [CNT_TOT_W-1:0] miss_total_q = '0;
    logic                 cur_policy = POL_FIFO;
    logic [FC_W-1:0]      cur_frames = FC_W'(64);

    access_result_t awaited_lookups [AWAIT_DEPTH];
    int             await_wr = 0;
    int             await_rd = 0;
    int             mismatches = 0;
    int             src_idle_pct = 0;
    int             sink_stall_pct = 0;
    int             quiet_cycles = 0;

    function automatic void age_out_above(input int r);
        int i;
        for (i = 0; i < MAX_FRAMES; i++) begin
            if (valid_mem[i] && rank_mem[i] > r)
                rank_mem[i] = rank_mem[i] - 1;
        end
    endfunction

    function automatic access_result_t lookup_page(input logic [PAGE_W-1:0] page);
        access_result_t r;
        int i;
        int slot;
        int limit;
        r = '0;
        slot = -1;
        for (i = 0; i < MAX_FRAMES; i++) begin
            if (slot < 0 && valid_mem[i] && tag_mem[i] == page)
                slot = i;
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            if (hit_total_q != '1)
                hit_total_q = hit_total_q + 1'b1;
            if (cur_policy == POL_LRU) begin
                age_out_above(rank_mem[slot]);
                rank_mem[slot] = n_filled - 1;
            end
        end else begin
            if (miss_total_q != '1)
                miss_total_q = miss_total_q + 1'b1;
            if (cur_frames == 0)
                limit = 1;
            else if (cur_frames > MAX_FRAMES)
                limit = MAX_FRAMES;
            else
                limit = int'(cur_frames);
            if (n_filled < limit) begin
                for (i = 0; i < MAX_FRAMES; i++) begin
                    if (slot < 0 && !valid_mem[i])
                        slot = i;
                end
                if (slot >= 0) begin
                    valid_mem[slot] = 1'b1;
                    tag_mem[slot] = page;
                    rank_mem[slot] = n_filled;
                    n_filled++;
                end
            end else if (n_filled > 0) begin
                for (i = 0; i < MAX_FRAMES; i++) begin
                    if (slot < 0 && valid_mem[i] && rank_mem[i] == 0)
                        slot = i;
                end
                if (slot >= 0) begin
                    r.victim_vld = 1'b1;
                    r.victim = tag_mem[slot];
                    age_out_above(0);
                    tag_mem[slot] = page;
                    rank_mem[slot] = n_filled - 1;
                end
            end
        end
        r.hits = hit_total_q;
        r.misses = miss_total_q;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [CNT_TOT_W-1:0] got,
                                   input logic [CNT_TOT_W-1:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        access_result_t got;
        access_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = access_result_t'(o_m_axis_tdata[RES_W-1:0]);
            if (await_rd == await_wr) begin
                report_mismatch("transfer with nothing awaited", got.misses, '0);
            end else begin
                want = awaited_lookups[await_rd % AWAIT_DEPTH];
                await_rd++;
                if (got.hit != want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.victim_vld != want.victim_vld)
                    report_mismatch("evict_valid", got.victim_vld, want.victim_vld);
                if (got.victim != want.victim)
                    report_mismatch("evicted_page", got.victim, want.victim);
                if (got.hits != want.hits)
                    report_mismatch("total_hits", got.hits, want.hits);
                if (got.misses != want.misses)
                    report_mismatch("total_misses", got.misses, want.misses);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            1: begin
                src_idle_pct = 65;
                sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct = 0;
                sink_stall_pct = 65;
            end
            default: begin
                src_idle_pct = 7;
                sink_stall_pct = 7;
            end
        endcase
    endtask

    task automatic send_page(input logic [PAGE_W-1:0] page);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= IN_TDATA_W'(page);
        do @(posedge i_clk); while (!o_s_axis_tready);
        awaited_lookups[await_wr % AWAIT_DEPTH] = lookup_page(page);
        await_wr++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (await_rd != await_wr)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FC_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_POLICY)
            cur_policy = val[0];
        else
            cur_frames = val;
    endtask

    // only once the table has gone quiet
    task automatic configure(input logic pol, input logic [FC_W-1:0] frames);
        drain();
        write_reg(CFG_POLICY, FC_W'(pol));
        write_reg(CFG_FRAMES, frames);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        set_idle(0);
        send_page('0);
        send_page('0);
        configure(POL_FIFO, '0);
        send_page('1);
        send_page('1);
        configure(POL_FIFO, FC_W'(1));
        send_page('0);
        configure(POL_LRU, FC_W'(2));
        send_page(PAGE_W'(1));
        send_page('0);
        send_page(PAGE_W'(2));
        configure(POL_FIFO, FC_W'(2));
        send_page(PAGE_W'(3));
        configure(POL_FIFO, '1);
        send_page(PAGE_W'('h55555));
        send_page(PAGE_W'('haaaaa));
        send_page(PAGE_W'('h12345));
        send_page(PAGE_W'(3));
        // fewer frames than already filled
        configure(POL_LRU, FC_W'(3));
        send_page(PAGE_W'(7));
        send_page(PAGE_W'('haaaaa));
        send_page(PAGE_W'(8));
    endtask

    task automatic test_random_phases();
        int frame_sizes[10];
        logic [PAGE_W-1:0] pool [POOL_DEPTH];
        logic [PAGE_W-1:0] page;
        int pool_n;
        int ph;
        int n;
        frame_sizes = '{4, 6, 8, 12, 16, 24, 32, 48, 64, 100};
        for (ph = 0; ph < 10; ph++) begin
            set_idle(ph % 4);
            configure((ph % 2) ? POL_LRU : POL_FIFO, FC_W'(frame_sizes[ph]));
            pool_n = frame_sizes[ph] + $urandom_range(1, frame_sizes[ph]);
            for (n = 0; n < pool_n; n++)
                pool[n] = PAGE_W'($urandom);
            for (n = 0; n < 85; n++) begin
                if ($urandom_range(0, 9) == 0)
                    page = PAGE_W'($urandom);
                else
                    page = pool[$urandom_range(0, pool_n - 1)];
                send_page(page);
            end
        end
    endtask

    task automatic test_full_table();
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] stride;
        logic [PAGE_W-1:0] page;
        int n;
        base = PAGE_W'($urandom);
        stride = PAGE_W'($urandom) | PAGE_W'(1);
        configure(POL_FIFO, FC_W'(MAX_FRAMES));
        for (n = 0; n < 560; n++) begin
            set_idle((n / 140) % 4);
            send_page(base + PAGE_W'(n) * stride);
        end
        configure(POL_LRU, '1);
        for (n = 0; n < 200; n++) begin
            set_idle((n / 50) % 4);
            if ($urandom_range(0, 4) == 0)
                page = PAGE_W'($urandom);
            else
                page = base + PAGE_W'($urandom_range(300, 559)) * stride;
            send_page(page);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_full_table();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: page_replacement_fifo_lru.f
rtl/prl_pkg.sv
rtl/prl_cell.sv
rtl/prl_tree.sv
rtl/page_replacement_fifo_lru.sv
bench/page_replacement_fifo_lru_tb.sv
